### hw/rtl/lsbt_pkg.sv
// ----------------------------------------------------------------------------
// lsbt_pkg
// Shared types and constants for the log sequencer backpointer table.
// ----------------------------------------------------------------------------
package lsbt_pkg;

  localparam int unsigned POS_W = 31;
  localparam int unsigned OUT_W = 32;

  localparam logic [POS_W-1:0] POS_SAT  = {POS_W{1'b1}};
  localparam logic [OUT_W-1:0] POS_NONE = {OUT_W{1'b1}};

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e;

  typedef struct packed {
    logic             alloc;
    logic             upd;
    logic [POS_W-1:0] pos;
  } entry_wr_t;

endpackage

### hw/rtl/lsbt_entry.sv
// ----------------------------------------------------------------------------
// lsbt_entry
// One table cell: valid bit, key, last position, and a local key compare.
// ----------------------------------------------------------------------------
module lsbt_entry #(
  parameter int unsigned KW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lsbt_pkg::entry_wr_t       wr_i,
  input  logic [KW-1:0]             key_i,
  output logic                      match_o,
  output logic [lsbt_pkg::POS_W-1:0] pos_o
);

  logic                       valid_q;
  logic [KW-1:0]              key_q;
  logic [lsbt_pkg::POS_W-1:0] pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.alloc) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.alloc) begin
      key_q <= key_i;
    end
    if (wr_i.alloc || wr_i.upd) begin
      pos_q <= wr_i.pos;
    end
  end

  assign match_o = valid_q && (key_q == key_i);
  assign pos_o   = pos_q;

endmodule

### hw/rtl/log_sequencer_backpointer_table_core.sv
// ----------------------------------------------------------------------------
// log_sequencer_backpointer_table_core
// Shared-log sequencer: hands out log positions and per-key backpointers.
// ----------------------------------------------------------------------------
// Path from input beat to result beat: input register, then result register.
// One beat per cycle when not stalled; all table entries compare the key in parallel.
// Reset: clears entry valid bits, fill count, position counter and both valid flags.
// Table contents need no clearing; no warm-up after reset.
module log_sequencer_backpointer_table_core #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] var_key_i,
  input  logic        last_of_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] back_pointer_o,
  output logic [1:0]  status_o
);

  localparam int unsigned KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned POS_W = lsbt_pkg::POS_W;
  localparam int unsigned OUT_W = lsbt_pkg::OUT_W;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_action_q;
  logic [KW-1:0]    s1_key_q;
  logic             s1_last_q;

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_pos_q, out_pos_d;
  logic [OUT_W-1:0] out_bp_q, out_bp_d;
  lsbt_pkg::status_e out_st_q, out_st_d;

  logic [POS_W-1:0] next_pos_q, next_pos_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             in_accept;
  logic             out_ready;
  logic             fire;
  logic             sat;
  logic             full;
  logic             hit;
  logic [POS_W-1:0] hit_pos;
  logic             do_alloc;
  logic             do_upd;

  logic [TABLE_ENTRIES-1:0] match;
  logic [POS_W-1:0]         ent_pos [TABLE_ENTRIES];
  lsbt_pkg::entry_wr_t      ent_wr  [TABLE_ENTRIES];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_key_q    <= var_key_i[KW-1:0];
      s1_last_q   <= last_of_request_i;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
    assign ent_wr[g].alloc = do_alloc && (cnt_q == CW'(g));
    assign ent_wr[g].upd   = do_upd && match[g];
    assign ent_wr[g].pos   = next_pos_q;

    lsbt_entry #(
      .KW (KW)
    ) u_entry (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (ent_wr[g]),
      .key_i   (s1_key_q),
      .match_o (match[g]),
      .pos_o   (ent_pos[g])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_pos = hit_pos | (match[i] ? ent_pos[i] : '0);
    end
  end

  assign hit  = |match;
  assign sat  = (next_pos_q == lsbt_pkg::POS_SAT);
  assign full = (cnt_q == CW'(TABLE_ENTRIES));

  always_comb begin
    out_pos_d  = lsbt_pkg::POS_NONE;
    out_bp_d   = lsbt_pkg::POS_NONE;
    out_st_d   = lsbt_pkg::ST_OK;
    do_alloc   = 1'b0;
    do_upd     = 1'b0;
    next_pos_d = next_pos_q;
    cnt_d      = cnt_q;
    if (s1_action_q == lsbt_pkg::ACT_READ) begin
      if (hit) begin
        out_pos_d = {1'b0, hit_pos};
      end
    end else if (sat) begin
      out_st_d = lsbt_pkg::ST_EXHAUSTED;
    end else begin
      out_pos_d = {1'b0, next_pos_q};
      if (hit) begin
        out_bp_d = {1'b0, hit_pos};
        do_upd   = fire;
      end else if (!full) begin
        do_alloc = fire;
        cnt_d    = fire ? CW'(cnt_q + 1'b1) : cnt_q;
      end else begin
        out_st_d = lsbt_pkg::ST_FULL;
      end
      if (fire && s1_last_q) begin
        next_pos_d = next_pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      next_pos_q  <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      next_pos_q  <= next_pos_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pos_q <= out_pos_d;
      out_bp_q  <= out_bp_d;
      out_st_q  <= out_st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_pos_q;
  assign back_pointer_o = out_bp_q;
  assign status_o       = out_st_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key stored in more than one entry");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (s1_action_q == lsbt_pkg::ACT_WRITE) && s1_last_q && !sat
    |=> next_pos_q == $past(next_pos_q) + 1'b1)
    else $error("position counter did not advance");

  a_exh_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_st_q == lsbt_pkg::ST_EXHAUSTED)
    |-> (out_pos_q == lsbt_pkg::POS_NONE) && (out_bp_q == lsbt_pkg::POS_NONE))
    else $error("exhausted result carries a position");
`endif

endmodule

### verif/tb_log_sequencer_backpointer_table_core.sv
// ----------------------------------------------------------------------------
// tb_log_sequencer_backpointer_table_core
// Self-checking bench for the shared-log sequencer. A directed table covers
// the empty table, key extremes, repeated keys inside one request and reads
// of unknown keys. It is followed by random write requests and reads drawn
// from key pools, which grow until the table overflows. An in-bench model of
// the position counter and the key table predicts every result beat that the
// directed table does not give, and both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_log_sequencer_backpointer_table_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned POOL_MAX    = 96;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned STALL_PCT   = 26;
  localparam int unsigned IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] back_pointer;
    lsbt_pkg::status_e  status;
  } grant_t;

  typedef struct packed {
    logic        act;
    logic [31:0] key;
    logic        last;
    logic        typed;
    grant_t      want;
  } probe_t;

  localparam probe_t DIRECTED_ROWS [19] = '{
    '{lsbt_pkg::ACT_READ,  32'h0000_0000, 1'b0, 1'b1,
      '{lsbt_pkg::POS_NONE, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_READ,  32'hFFFF_FFFF, 1'b0, 1'b1,
      '{lsbt_pkg::POS_NONE, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'h0000_0000, 1'b1, 1'b1,
      '{32'd0, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'd1, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'd1, 32'd1, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_READ,  32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'd1, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_READ,  32'h0000_0000, 1'b0, 1'b1,
      '{32'd0, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_READ,  32'h0000_0000, 1'b1, 1'b1,
      '{32'd0, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'h0000_0000, 1'b1, 1'b1,
      '{32'd2, 32'd0, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{lsbt_pkg::ACT_WRITE, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{lsbt_pkg::ACT_WRITE, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{lsbt_pkg::ACT_READ,  32'h5555_5555, 1'b0, 1'b0, '0},
    '{lsbt_pkg::ACT_READ,  32'hAAAA_AAAA, 1'b1, 1'b0, '0},
    '{lsbt_pkg::ACT_READ,  32'h1234_5678, 1'b0, 1'b1,
      '{lsbt_pkg::POS_NONE, lsbt_pkg::POS_NONE, lsbt_pkg::ST_OK}},
    '{lsbt_pkg::ACT_WRITE, 32'h8000_0000, 1'b1, 1'b0, '0},
    '{lsbt_pkg::ACT_WRITE, 32'h0000_0001, 1'b1, 1'b0, '0},
    '{lsbt_pkg::ACT_READ,  32'h8000_0000, 1'b0, 1'b0, '0},
    '{lsbt_pkg::ACT_READ,  32'h0000_0001, 1'b0, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [31:0] var_key_i;
  logic        last_of_request_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [31:0] position_o;
  logic signed [31:0] back_pointer_o;
  logic [1:0]  status_o;

  logic [31:0]                key_tbl [ENTRIES];
  logic [lsbt_pkg::POS_W-1:0] pos_tbl [ENTRIES];
  logic                       used_tbl [ENTRIES];
  logic [lsbt_pkg::POS_W-1:0] next_pos;

  grant_t      expected_grants [$];
  logic [31:0] key_pool [POOL_MAX];
  bit          calm;
  bit          hold_go;
  int          errors;
  int          idle_cycles;
  int          n_writes;
  int          n_reads;
  int          n_backptrs;
  int          n_full;

  log_sequencer_backpointer_table_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .var_key_i        (var_key_i),
    .last_of_request_i(last_of_request_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_o       (position_o),
    .back_pointer_o   (back_pointer_o),
    .status_o         (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic grant_t issue_grant(input logic act, input logic [31:0] key,
                                         input logic last);
    grant_t g;
    int     hit;
    int     free_slot;
    hit       = -1;
    free_slot = -1;
    g.position     = lsbt_pkg::POS_NONE;
    g.back_pointer = lsbt_pkg::POS_NONE;
    g.status       = lsbt_pkg::ST_OK;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && used_tbl[i] && key_tbl[i] == key) hit = i;
      if (free_slot < 0 && !used_tbl[i]) free_slot = i;
    end
    if (act == lsbt_pkg::ACT_READ) begin
      n_reads++;
      if (hit >= 0) g.position = {1'b0, pos_tbl[hit]};
    end else if (next_pos == lsbt_pkg::POS_SAT) begin
      n_writes++;
      g.status = lsbt_pkg::ST_EXHAUSTED;
    end else begin
      n_writes++;
      g.position = {1'b0, next_pos};
      if (hit >= 0) begin
        g.back_pointer = {1'b0, pos_tbl[hit]};
        pos_tbl[hit]   = next_pos;
        n_backptrs++;
      end else if (free_slot >= 0) begin
        used_tbl[free_slot] = 1'b1;
        key_tbl[free_slot]  = key;
        pos_tbl[free_slot]  = next_pos;
      end else begin
        g.status = lsbt_pkg::ST_FULL;
        n_full++;
      end
      if (last) next_pos = next_pos + 1'b1;
    end
    return g;
  endfunction

  function automatic logic [31:0] pick_key(input int pool_n, input int wild_pct);
    if ($urandom_range(0, 99) < wild_pct) return $urandom;
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send_beat(input logic act, input logic [31:0] key, input logic last,
                           input logic typed, input grant_t want);
    grant_t guess;
    if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < STALL_PCT);
    end
    in_valid_i        <= 1'b1;
    action_i          <= act;
    var_key_i         <= key;
    last_of_request_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    guess = issue_grant(act, key, last);
    expected_grants.push_back(typed ? want : guess);
  endtask

  task automatic run_requests(input int n_beats, input int pool_n, input int wild_pct);
    int          sent;
    int          len;
    logic [31:0] key;
    sent = 0;
    key  = pick_key(pool_n, wild_pct);
    while (sent < n_beats) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(lsbt_pkg::ACT_READ, pick_key(pool_n, wild_pct),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 99) >= 15) key = pick_key(pool_n, wild_pct);
          send_beat(lsbt_pkg::ACT_WRITE, key, j == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < STALL_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result beat with nothing pending", position_o, '1);
      end else begin
        want = expected_grants.pop_front();
        if (position_o !== want.position)
          report_mismatch("position", position_o, want.position);
        if (back_pointer_o !== want.back_pointer)
          report_mismatch("back_pointer", back_pointer_o, want.back_pointer);
        if (status_o !== want.status)
          report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved in %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    action_i          <= lsbt_pkg::ACT_WRITE;
    var_key_i         <= '0;
    last_of_request_i <= 1'b0;
    calm        = 1'b0;
    hold_go     = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    n_writes    = 0;
    n_reads     = 0;
    n_backptrs  = 0;
    n_full      = 0;
    next_pos    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      used_tbl[i] = 1'b0;
      key_tbl[i]  = '0;
      pos_tbl[i]  = '0;
    end
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_beat(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].last,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    run_requests(500, 48, 0);

    calm    = 1'b1;
    hold_go = 1'b1;
    run_requests(40, 48, 5);
    run_requests(300, 48, 5);
    calm = 1'b0;

    run_requests(860, POOL_MAX, 10);

    in_valid_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d writes and %0d reads; %0d backpointer hits, %0d table-full answers",
             n_writes, n_reads, n_backptrs, n_full);
    $display("log counter ended at %0d with %0d mismatches", next_pos, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
